>>> design/pcbe_pkg.sv
// Package: shared constants and types for the Bezier evaluator
package pcbe_pkg;
  localparam int MAX_SEGMENTS_DEF       = 16;
  localparam int COORD_BITS_DEF         = 24;
  localparam int PROGRESS_FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_BITS           = 2;
  localparam int CFG_DATA_BITS          = 24;
  localparam int SEG_CNT_BITS           = 5;
  localparam int SEG_IDX_BITS           = 4;
  localparam int SLOT_BITS              = 2;
  localparam int PROG_BITS              = 17;
  localparam int POINTS_PER_SEG         = 3;

  typedef enum logic [1:0] {
    CFG_SEGMENT_COUNT = 2'd0,
    CFG_START_X       = 2'd1,
    CFG_START_Y       = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    SLOT_CTRL1 = 2'd0,
    SLOT_CTRL2 = 2'd1,
    SLOT_END   = 2'd2,
    SLOT_NONE  = 2'd3
  } slot_t;
endpackage

>>> design/pcbe_if.sv
// Interfaces: valid/ready channels for input and result beats
interface pcbe_in_if #(parameter int COORD_BITS = 24);
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [pcbe_pkg::SEG_IDX_BITS-1:0]   segment_index;
  logic [pcbe_pkg::SLOT_BITS-1:0]      point_slot;
  logic signed [COORD_BITS-1:0]        point_x;
  logic signed [COORD_BITS-1:0]        point_y;
  logic [pcbe_pkg::PROG_BITS-1:0]      progress;
  modport source (output valid, cmd, segment_index, point_slot, point_x, point_y, progress,
                  input ready);
  modport sink   (input valid, cmd, segment_index, point_slot, point_x, point_y, progress,
                  output ready);
endinterface

interface pcbe_out_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] curve_x;
  logic signed [COORD_BITS-1:0] curve_y;
  logic                         error;
  modport source (output valid, curve_x, curve_y, error, input ready);
  modport sink   (input valid, curve_x, curve_y, error, output ready);
endinterface

>>> design/pcbe_ram.sv
// Generic single-write, single-read RAM with registered read data
module pcbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> design/pcbe_front.sv
// Front end: takes beats, writes loads, turns evaluates into segment jobs
module pcbe_front #(
  parameter int MAX_SEGMENTS       = pcbe_pkg::MAX_SEGMENTS_DEF,
  parameter int PROGRESS_FRAC_BITS = pcbe_pkg::PROGRESS_FRAC_BITS_DEF,
  parameter int COORD_BITS         = pcbe_pkg::COORD_BITS_DEF,
  localparam int SIDX_BITS         = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [pcbe_pkg::SEG_IDX_BITS-1:0]    in_segment_index,
  input  logic [pcbe_pkg::SLOT_BITS-1:0]       in_point_slot,
  input  logic [pcbe_pkg::PROG_BITS-1:0]       in_progress,
  input  logic [pcbe_pkg::SEG_CNT_BITS-1:0]    segment_count,
  // high when no queued evaluation still has to read the table
  input  logic                                 load_ok,
  output logic                                 wr_en,
  output logic [SIDX_BITS-1:0]                 wr_seg,
  output logic [pcbe_pkg::SLOT_BITS-1:0]       wr_slot,
  // job to queue
  output logic                                 job_valid,
  input  logic                                 job_ready,
  output logic                                 job_error,
  output logic [SIDX_BITS-1:0]                 job_seg,
  output logic [PROGRESS_FRAC_BITS:0]          job_t
);
  localparam int NB = $clog2(MAX_SEGMENTS + 1);
  localparam int PB = PROGRESS_FRAC_BITS + 1;
  localparam logic [PB-1:0] ONE_T = PB'(1) << PROGRESS_FRAC_BITS;

  logic [NB-1:0]    n;
  logic [PB-1:0]    p;
  logic [NB+PB-1:0] scaled;
  logic [NB+PB-1:0] idx;
  logic             acc;

  // evaluates need queue room; loads wait for earlier evaluates to read the table
  assign in_ready = (in_cmd == pcbe_pkg::CMD_EVAL) ? job_ready : load_ok;
  assign acc      = in_valid && in_ready;

  always_comb begin
    if (32'(segment_count) > MAX_SEGMENTS) n = NB'(MAX_SEGMENTS);
    else n = NB'(segment_count);
    if (32'(in_progress) > 32'(ONE_T) || in_progress[pcbe_pkg::PROG_BITS-1:0] > 
        pcbe_pkg::PROG_BITS'(ONE_T)) p = ONE_T;
    else p = PB'(in_progress);
    scaled = (NB+PB)'(n) * (NB+PB)'(p);
    idx    = scaled >> PROGRESS_FRAC_BITS;
    job_error = (n == '0);
    if (idx >= (NB+PB)'(n)) begin
      job_seg = SIDX_BITS'(n - NB'(1));
      job_t   = ONE_T;
    end else begin
      job_seg = SIDX_BITS'(idx);
      job_t   = PB'(scaled[PROGRESS_FRAC_BITS-1:0]);
    end
  end

  assign job_valid = in_valid && (in_cmd == pcbe_pkg::CMD_EVAL);
  assign wr_en = acc && (in_cmd == pcbe_pkg::CMD_LOAD) &&
                 (in_point_slot != pcbe_pkg::SLOT_NONE) &&
                 (32'(in_segment_index) < MAX_SEGMENTS);
  assign wr_seg  = SIDX_BITS'(in_segment_index);
  assign wr_slot = in_point_slot;

  logic unused_ok;
  assign unused_ok = clk ^ rst_n;
endmodule

>>> design/pcbe_queue.sv
// Two-entry queue between front end and evaluation pipeline
module pcbe_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [WIDTH-1:0] m_data,
  output logic             one_left
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;

  assign s_ready  = (cnt_r != 2'd2);
  assign m_valid  = (cnt_r != 2'd0);
  assign one_left = (cnt_r == 2'd1);
  assign m_data   = mem_r[rp_r];
  assign push     = s_valid && s_ready;
  assign pop      = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= s_data;
  end
endmodule

>>> design/pcbe_back.sv
// Back end: table read then three pipelined de Casteljau levels
module pcbe_back #(
  parameter int MAX_SEGMENTS       = pcbe_pkg::MAX_SEGMENTS_DEF,
  parameter int PROGRESS_FRAC_BITS = pcbe_pkg::PROGRESS_FRAC_BITS_DEF,
  parameter int COORD_BITS         = pcbe_pkg::COORD_BITS_DEF,
  localparam int SIDX_BITS         = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [SIDX_BITS-1:0]         wr_seg,
  input  logic [pcbe_pkg::SLOT_BITS-1:0] wr_slot,
  input  logic [2*COORD_BITS-1:0]      wr_data,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  logic                         job_error,
  input  logic [SIDX_BITS-1:0]         job_seg,
  input  logic [PROGRESS_FRAC_BITS:0]  job_t,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_error
);
  localparam int C  = COORD_BITS;
  localparam int F  = PROGRESS_FRAC_BITS;
  localparam int DW = C + 1;
  localparam int PW = DW + F + 2;

  function automatic logic signed [C-1:0] lerp(input logic signed [C-1:0] a,
                                              input logic signed [C-1:0] b,
                                              input logic [F:0] t);
    logic signed [PW-1:0] pr;
    pr = PW'(DW'(b) - DW'(a)) * $signed({1'b0, t});
    pr = pr + PW'(1 << (F - 1));
    return C'(PW'(a) + (pr >>> F));
  endfunction

  // pipeline advances whenever output slot is free or being drained
  logic adv;
  logic [3:0] v_r;
  logic [3:0] e_r;
  logic [F:0] t_r [3];
  logic       sz_r [1];
  logic signed [C-1:0] sx_r, sy_r;
  logic signed [C-1:0] a_r [2][1:3];
  logic signed [C-1:0] b_r [2][1:2];
  logic signed [C-1:0] c_r [2][1:1];
  logic       ov_r;

  assign adv       = !ov_r || out_ready;
  assign job_ready = adv;

  // memories: one per slot, read in parallel; u_prev keeps each end point
  // one segment up so it reads as the next segment's start
  logic [2*C-1:0] rd [3];
  logic [2*C-1:0] prv;
  genvar g;
  for (g = 0; g < 3; g++) begin : g_slot
    pcbe_ram #(.WIDTH(2*C), .DEPTH(MAX_SEGMENTS)) u_ram (
      .clk(clk), .we(wr_en && (32'(wr_slot) == g)),
      .waddr(wr_seg), .wdata(wr_data),
      .re(adv), .raddr(job_seg), .rdata(rd[g]));
  end
  pcbe_ram #(.WIDTH(2*C), .DEPTH(MAX_SEGMENTS)) u_prev (
    .clk(clk),
    .we(wr_en && (wr_slot == pcbe_pkg::SLOT_END) && (32'(wr_seg) < MAX_SEGMENTS - 1)),
    .waddr(wr_seg + SIDX_BITS'(1)), .wdata(wr_data),
    .re(adv), .raddr(job_seg), .rdata(prv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0; ov_r <= 1'b0;
    end else if (adv) begin
      v_r  <= {v_r[2:0], job_valid};
      ov_r <= v_r[3];
    end
    if (adv) begin
      e_r[0] <= job_error; t_r[0] <= job_t; sz_r[0] <= (job_seg == '0);
      sx_r <= start_x; sy_r <= start_y;
      for (int k = 0; k < 2; k++) begin
        a_r[k][1] <= lerp(sz_r[0] ? (k == 0 ? sx_r : sy_r) : prv[k*C +: C],
                          rd[0][k*C +: C], t_r[0]);
        b_r[k][1] <= lerp(rd[0][k*C +: C], rd[1][k*C +: C], t_r[0]);
        c_r[k][1] <= lerp(rd[1][k*C +: C], rd[2][k*C +: C], t_r[0]);
        a_r[k][2] <= lerp(a_r[k][1], b_r[k][1], t_r[1]);
        b_r[k][2] <= lerp(b_r[k][1], c_r[k][1], t_r[1]);
        a_r[k][3] <= lerp(a_r[k][2], b_r[k][2], t_r[2]);
      end
      for (int s = 1; s < 4; s++) e_r[s] <= e_r[s-1];
      for (int s = 1; s < 3; s++) t_r[s] <= t_r[s-1];
      out_error <= e_r[3];
      out_x <= e_r[3] ? '0 : a_r[0][3];
      out_y <= e_r[3] ? '0 : a_r[1][3];
    end
  end
  assign out_valid = ov_r;
endmodule

>>> design/piecewise_cubic_bezier_eval_top.sv
// Top level: piecewise cubic Bezier evaluator
// Use:
//   in channel: one beat per item. cmd load writes point (point_x, point_y)
//   into slot point_slot of segment segment_index; no result beat. cmd
//   evaluate gives progress (Q1.16, 65536 = end) and yields one out beat.
//   out channel: curve_x, curve_y (Q15.8) and error (segment count zero).
//   cfg port: index 0 segment_count, 1 start_x, 2 start_y; write when idle.
// Throughput: one item per cycle while out_ready stays high.
// Path: an accepted evaluate beat passes the job queue, the table read, the
//   three lerp levels of the de Casteljau pipeline and the output register.
// Reset: rst_n low clears control state and config registers; point table
//   holds garbage until loaded, no clearing pass.
// Stall: when out_ready is low with an out beat waiting, the pipeline holds;
//   the two-entry job queue fills, then in_ready drops. A load waits until
//   every evaluate ahead of it has read the table, so it never overtakes
//   one; with the pipe flowing that does not hold the load back.
module piecewise_cubic_bezier_eval_top #(
  parameter int MAX_SEGMENTS       = pcbe_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS         = pcbe_pkg::COORD_BITS_DEF,
  parameter int PROGRESS_FRAC_BITS = pcbe_pkg::PROGRESS_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pcbe_in_if.sink                            in_ch,
  pcbe_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [pcbe_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [COORD_BITS-1:0]              cfg_data
);
  localparam int SIDX_BITS = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int JW        = 1 + SIDX_BITS + PROGRESS_FRAC_BITS + 1;

  // configuration registers
  logic [pcbe_pkg::SEG_CNT_BITS-1:0] seg_cnt_r;
  logic signed [COORD_BITS-1:0]      start_x_r, start_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= '0; start_x_r <= '0; start_y_r <= '0;
    end else if (cfg_we) begin
      case (pcbe_pkg::cfg_idx_t'(cfg_idx))
        pcbe_pkg::CFG_SEGMENT_COUNT: seg_cnt_r <= cfg_data[pcbe_pkg::SEG_CNT_BITS-1:0];
        pcbe_pkg::CFG_START_X:       start_x_r <= cfg_data;
        pcbe_pkg::CFG_START_Y:       start_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                           wr_en;
  logic [SIDX_BITS-1:0]           wr_seg;
  logic [pcbe_pkg::SLOT_BITS-1:0] wr_slot;
  logic                           fj_valid, fj_ready, fj_err;
  logic [SIDX_BITS-1:0]           fj_seg;
  logic [PROGRESS_FRAC_BITS:0]    fj_t;
  logic [JW-1:0]                  qd;
  logic                           bj_valid, bj_ready;
  logic                           q_one, ld_ok;

  // queue empty, or its only job reads the table at this edge
  assign ld_ok = !bj_valid || (q_one && bj_ready);

  pcbe_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS),
               .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd), .in_segment_index(in_ch.segment_index),
    .in_point_slot(in_ch.point_slot), .in_progress(in_ch.progress),
    .segment_count(seg_cnt_r), .load_ok(ld_ok), .wr_en(wr_en), .wr_seg(wr_seg),
    .wr_slot(wr_slot), .job_valid(fj_valid), .job_ready(fj_ready), .job_error(fj_err),
    .job_seg(fj_seg), .job_t(fj_t));

  pcbe_queue #(.WIDTH(JW)) u_queue (
    .clk(clk), .rst_n(rst_n), .s_valid(fj_valid), .s_ready(fj_ready),
    .s_data({fj_err, fj_seg, fj_t}), .m_valid(bj_valid), .m_ready(bj_ready),
    .m_data(qd), .one_left(q_one));

  pcbe_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS),
              .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_seg(wr_seg), .wr_slot(wr_slot),
    .wr_data({in_ch.point_y, in_ch.point_x}), .start_x(start_x_r), .start_y(start_y_r),
    .job_valid(bj_valid), .job_ready(bj_ready), .job_error(qd[JW-1]),
    .job_seg(qd[PROGRESS_FRAC_BITS+1 +: SIDX_BITS]), .job_t(qd[PROGRESS_FRAC_BITS:0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_x(out_ch.curve_x),
    .out_y(out_ch.curve_y), .out_error(out_ch.error));
endmodule

>>> design/pcbe_checker.sv
// Checker: port-level assertions bound to the top level
module pcbe_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_error,
  input logic [23:0] curve_x
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out beat dropped");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> curve_x == '0) else $error("error beat not zero");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");
  a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_ready)) else $error("in ready unknown");
endmodule

bind piecewise_cubic_bezier_eval_top pcbe_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_error(out_ch.error),
  .curve_x(out_ch.curve_x[23:0]));
